@@ sv/fct_pkg.sv @@
package fct_pkg;

   localparam int NUM_PLANES       = 6;
   localparam int COORD_WIDTH_DEF  = 22;
   localparam int NORMAL_WIDTH_DEF = 14;
   localparam int PLANE_WIDTH      = 64;
   localparam int CSR_INDEX_WIDTH  = 3;

   localparam logic [1:0] CMD_BOX    = 2'd0;
   localparam logic [1:0] CMD_SPHERE = 2'd1;
   localparam logic [1:0] CMD_POINT  = 2'd2;

   localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

   typedef struct packed {
      logic outside;
      logic partial;
   } plane_flags_type;

endpackage

@@ sv/fct_plane_eval.sv @@
module fct_plane_eval #(
   parameter int COORD_WIDTH  = fct_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = fct_pkg::NORMAL_WIDTH_DEF
) (
   input  logic [fct_pkg::PLANE_WIDTH-1:0] plane,
   input  logic [1:0]                      command,
   input  logic signed [COORD_WIDTH-1:0]   a_x,
   input  logic signed [COORD_WIDTH-1:0]   a_y,
   input  logic signed [COORD_WIDTH-1:0]   a_z,
   input  logic signed [COORD_WIDTH-1:0]   b_x,
   input  logic signed [COORD_WIDTH-1:0]   b_y,
   input  logic signed [COORD_WIDTH-1:0]   b_z,
   input  logic [COORD_WIDTH-2:0]          radius,
   output fct_pkg::plane_flags_type        flags
);

   localparam int FRAC_BITS = NORMAL_WIDTH - 2;
   localparam int PROD_WIDTH = NORMAL_WIDTH + COORD_WIDTH;
   localparam int SUM_WIDTH = NORMAL_WIDTH + COORD_WIDTH + 2;

   logic [fct_pkg::PLANE_WIDTH+COORD_WIDTH-1:0] plane_ext;
   logic signed [NORMAL_WIDTH-1:0] nx, ny, nz;
   logic signed [COORD_WIDTH-1:0]  d;
   logic                           is_box, is_sphere;
   logic signed [COORD_WIDTH-1:0]  px, py, pz, qx, qy, qz;
   logic signed [PROD_WIDTH-1:0]   ppx, ppy, ppz, pqx, pqy, pqz;
   logic signed [SUM_WIDTH-1:0]    d_scaled, r_scaled, dist_p, dist_q, thr_lo, thr_hi;

   assign plane_ext = {{COORD_WIDTH{1'b0}}, plane};
   assign nx = plane_ext[0 +: NORMAL_WIDTH];
   assign ny = plane_ext[NORMAL_WIDTH +: NORMAL_WIDTH];
   assign nz = plane_ext[2*NORMAL_WIDTH +: NORMAL_WIDTH];
   assign d  = plane_ext[3*NORMAL_WIDTH +: COORD_WIDTH];

   assign is_box    = (command == fct_pkg::CMD_BOX);
   assign is_sphere = (command == fct_pkg::CMD_SPHERE);

   // positive vertex toward the normal, negative vertex away from it
   assign px = (is_box && !nx[NORMAL_WIDTH-1]) ? b_x : a_x;
   assign py = (is_box && !ny[NORMAL_WIDTH-1]) ? b_y : a_y;
   assign pz = (is_box && !nz[NORMAL_WIDTH-1]) ? b_z : a_z;
   assign qx = (is_box && nx[NORMAL_WIDTH-1]) ? b_x : a_x;
   assign qy = (is_box && ny[NORMAL_WIDTH-1]) ? b_y : a_y;
   assign qz = (is_box && nz[NORMAL_WIDTH-1]) ? b_z : a_z;

   assign ppx = nx * px;
   assign ppy = ny * py;
   assign ppz = nz * pz;
   assign pqx = nx * qx;
   assign pqy = ny * qy;
   assign pqz = nz * qz;

   assign d_scaled = SUM_WIDTH'(d) <<< FRAC_BITS;
   assign r_scaled = SUM_WIDTH'({1'b0, radius}) <<< FRAC_BITS;

   assign dist_p = SUM_WIDTH'(ppx) + SUM_WIDTH'(ppy) + SUM_WIDTH'(ppz) + d_scaled;
   assign dist_q = SUM_WIDTH'(pqx) + SUM_WIDTH'(pqy) + SUM_WIDTH'(pqz) + d_scaled;

   assign thr_lo = is_sphere ? -r_scaled : '0;
   assign thr_hi = is_sphere ? r_scaled : '0;

   assign flags.outside = (dist_p < thr_lo);
   assign flags.partial = (dist_q < thr_hi);

endmodule

@@ sv/frustum_cull_test_core.sv @@
// flow: a request transfer loads the input register, and rsp_valid rises when
// the query moves on into the result register, once that register is free
// throughput: one query per cycle while responses are taken, all six planes evaluated in parallel
// stalls: req_ready drops only while both registers hold a query and rsp_ready is low
// reset: synchronous, clears both valid flags and the six plane registers to zero
module frustum_cull_test_core #(
   parameter int COORD_WIDTH  = fct_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_WIDTH = fct_pkg::NORMAL_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic signed [COORD_WIDTH-1:0]       req_a_x,
   input  logic signed [COORD_WIDTH-1:0]       req_a_y,
   input  logic signed [COORD_WIDTH-1:0]       req_a_z,
   input  logic signed [COORD_WIDTH-1:0]       req_b_x,
   input  logic signed [COORD_WIDTH-1:0]       req_b_y,
   input  logic signed [COORD_WIDTH-1:0]       req_b_z,
   input  logic [COORD_WIDTH-2:0]              req_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_verdict,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fct_pkg::PLANE_WIDTH-1:0]     csr_data
);

   typedef struct packed {
      logic [1:0]                    command;
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] a_z;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] b_z;
      logic [COORD_WIDTH-2:0]        radius;
   } query_type;

   logic [fct_pkg::PLANE_WIDTH-1:0] plane_ff [fct_pkg::NUM_PLANES];
   logic [fct_pkg::PLANE_WIDTH-1:0] plane_in [fct_pkg::NUM_PLANES];

   logic      s1_valid_ff, s1_valid_in;
   query_type query_ff, query_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [1:0] verdict_ff, verdict_in;
   logic      s2_advance, req_transfer;

   fct_pkg::plane_flags_type flags [fct_pkg::NUM_PLANES];
   logic [fct_pkg::NUM_PLANES-1:0] outside_vec, partial_vec;

   assign csr_ready = 1'b1;

   // plane registers
   always_comb begin
      for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
         plane_in[i] = plane_ff[i];
         if (csr_valid && (csr_index == fct_pkg::CSR_INDEX_WIDTH'(i))) begin
            plane_in[i] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else begin
         plane_ff <= plane_in;
      end
   end

   // pipeline control
   assign s2_advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || s2_advance;
   assign req_transfer = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      query_in    = query_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      if (req_transfer) begin
         query_in = '{command: req_command, a_x: req_a_x, a_y: req_a_y, a_z: req_a_z,
                      b_x: req_b_x, b_y: req_b_y, b_z: req_b_z, radius: req_radius};
      end
   end

   // per-plane lanes
   for (genvar g = 0; g < fct_pkg::NUM_PLANES; g++) begin : g_plane
      fct_plane_eval #(
         .COORD_WIDTH  (COORD_WIDTH),
         .NORMAL_WIDTH (NORMAL_WIDTH)
      ) u_plane_eval (
         .plane   (plane_ff[g]),
         .command (query_ff.command),
         .a_x     (query_ff.a_x),
         .a_y     (query_ff.a_y),
         .a_z     (query_ff.a_z),
         .b_x     (query_ff.b_x),
         .b_y     (query_ff.b_y),
         .b_z     (query_ff.b_z),
         .radius  (query_ff.radius),
         .flags   (flags[g])
      );
      assign outside_vec[g] = flags[g].outside;
      assign partial_vec[g] = flags[g].partial;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      if (s2_advance) begin
         rsp_valid_in = s1_valid_ff;
         priority if (|outside_vec) begin
            verdict_in = fct_pkg::VERDICT_OUTSIDE;
         end else if (|partial_vec) begin
            verdict_in = fct_pkg::VERDICT_INTERSECT;
         end else begin
            verdict_in = fct_pkg::VERDICT_INSIDE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff   <= query_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   // a query in the input register moves to the result register when it is free
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_advance) |=> rsp_valid_ff)
      else $error("query lost between input and result register");

   // an accepted request always lands in the input register
   a_req_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_transfer |=> s1_valid_ff)
      else $error("request transfer not captured");

   // a point query, or one with the reserved command, never reports intersecting
   a_point_verdict: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_advance &&
       query_ff.command != fct_pkg::CMD_BOX && query_ff.command != fct_pkg::CMD_SPHERE)
      |=> (verdict_ff != fct_pkg::VERDICT_INTERSECT))
      else $error("point query reported intersecting");

   // a write to the left plane register takes effect on the next edge
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == '0) |=> (plane_ff[0] == $past(csr_data)))
      else $error("left plane register write lost");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int CW = fct_pkg::COORD_WIDTH_DEF;
   localparam int NW = fct_pkg::NORMAL_WIDTH_DEF;
   localparam int FRAC = NW - 2;
   localparam longint SCALE = longint'(1) << FRAC;
   localparam int UNIT_NORMAL = 1 << FRAC;
   localparam int NORMAL_MAX = (1 << (NW - 1)) - 1;
   localparam int NORMAL_MIN = -(1 << (NW - 1));
   localparam int COORD_MAX = (1 << (CW - 1)) - 1;
   localparam int COORD_MIN = -(1 << (CW - 1));
   localparam int RADIUS_MAX = (1 << (CW - 1)) - 1;
   localparam int CUBE_HALF = 1000;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   typedef enum logic [fct_pkg::CSR_INDEX_WIDTH-1:0] {
      PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR,
      CSR_SPARE_A, CSR_SPARE_B
   } csr_index_type;

   typedef struct {
      logic [1:0] command;
      logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
      logic [CW-2:0] radius;
   } query_type;

   typedef struct {
      longint nx, ny, nz, d;
   } plane_coeffs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = fct_pkg::CMD_BOX;
   logic signed [CW-1:0] req_a_x = '0;
   logic signed [CW-1:0] req_a_y = '0;
   logic signed [CW-1:0] req_a_z = '0;
   logic signed [CW-1:0] req_b_x = '0;
   logic signed [CW-1:0] req_b_y = '0;
   logic signed [CW-1:0] req_b_z = '0;
   logic [CW-2:0] req_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_verdict;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [fct_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [fct_pkg::PLANE_WIDTH-1:0] csr_data = '0;

   logic [fct_pkg::PLANE_WIDTH-1:0] plane_shadow [fct_pkg::NUM_PLANES];
   logic [1:0] expected_verdicts [$];
   int error_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit idle_bursts = 1'b0;

   frustum_cull_test_core #(
      .COORD_WIDTH(CW),
      .NORMAL_WIDTH(NW)
   ) dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (idle_bursts && $urandom_range(0, 3) == 0) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin : verdict_check
      logic [1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t unexpected verdict transfer: expected none, actual %0d",
                     $time, rsp_verdict);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_verdict !== want) begin
               $display("%0t verdict mismatch: expected %0d, actual %0d",
                        $time, want, rsp_verdict);
               error_count++;
            end
         end
      end
   end

   function automatic plane_coeffs_type unpack_plane(
         input logic [fct_pkg::PLANE_WIDTH-1:0] bits);
      plane_coeffs_type c;
      c.nx = $signed(bits[NW-1:0]);
      c.ny = $signed(bits[2*NW-1:NW]);
      c.nz = $signed(bits[3*NW-1:2*NW]);
      c.d = $signed(bits[3*NW +: CW]);
      return c;
   endfunction

   function automatic longint plane_distance(input plane_coeffs_type c,
                                             input longint x, y, z);
      return c.nx * x + c.ny * y + c.nz * z + c.d * SCALE;
   endfunction

   function automatic logic [1:0] cull_verdict(input query_type q);
      plane_coeffs_type c;
      longint ax, ay, az, bx, by, bz, rs, s;
      bit no_partial;
      ax = q.a_x;
      ay = q.a_y;
      az = q.a_z;
      bx = q.b_x;
      by = q.b_y;
      bz = q.b_z;
      rs = longint'(q.radius) * SCALE;
      no_partial = 1'b1;
      for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
         c = unpack_plane(plane_shadow[i]);
         case (q.command)
            fct_pkg::CMD_BOX: begin
               s = plane_distance(c, c.nx >= 0 ? bx : ax, c.ny >= 0 ? by : ay,
                                  c.nz >= 0 ? bz : az);
               if (s < 0) return fct_pkg::VERDICT_OUTSIDE;
               s = plane_distance(c, c.nx >= 0 ? ax : bx, c.ny >= 0 ? ay : by,
                                  c.nz >= 0 ? az : bz);
               if (s < 0) no_partial = 1'b0;
            end
            fct_pkg::CMD_SPHERE: begin
               s = plane_distance(c, ax, ay, az);
               if (s < -rs) return fct_pkg::VERDICT_OUTSIDE;
               if (s < rs) no_partial = 1'b0;
            end
            default: begin
               if (plane_distance(c, ax, ay, az) < 0) return fct_pkg::VERDICT_OUTSIDE;
            end
         endcase
      end
      return no_partial ? fct_pkg::VERDICT_INSIDE : fct_pkg::VERDICT_INTERSECT;
   endfunction

   function automatic logic [fct_pkg::PLANE_WIDTH-1:0] pack_plane(input int nx, ny, nz, d);
      logic [NW-1:0] fx, fy, fz;
      logic [CW-1:0] fd;
      fx = NW'(nx);
      fy = NW'(ny);
      fz = NW'(nz);
      fd = CW'(d);
      return {fd, fz, fy, fx};
   endfunction

   function automatic int rand_signed(input int mag);
      return int'($urandom_range(0, 2 * mag)) - mag;
   endfunction

   task automatic send_query(input logic [1:0] command, input int ax, ay, az,
                             input int bx, by, bz, radius);
      query_type q;
      q.command = command;
      q.a_x = CW'(ax);
      q.a_y = CW'(ay);
      q.a_z = CW'(az);
      q.b_x = CW'(bx);
      q.b_y = CW'(by);
      q.b_z = CW'(bz);
      q.radius = (CW - 1)'(radius);
      @(negedge clock);
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_command = q.command;
      req_a_x = q.a_x;
      req_a_y = q.a_y;
      req_a_z = q.a_z;
      req_b_x = q.b_x;
      req_b_y = q.b_y;
      req_b_z = q.b_z;
      req_radius = q.radius;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_verdicts.push_back(cull_verdict(q));
   endtask

   task automatic send_random_query(input int span);
      logic [1:0] command;
      int ax, ay, az, sx, sy, sz;
      if ($urandom_range(0, 9) == 0) begin
         send_query(2'($urandom_range(fct_pkg::CMD_BOX, CMD_RESERVED)),
                    $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
      end else begin
         command = ($urandom_range(0, 19) == 0)
                   ? CMD_RESERVED
                   : 2'($urandom_range(fct_pkg::CMD_BOX, fct_pkg::CMD_POINT));
         ax = rand_signed(span + span / 2);
         ay = rand_signed(span + span / 2);
         az = rand_signed(span + span / 2);
         sx = $urandom_range(0, span);
         sy = $urandom_range(0, span);
         sz = $urandom_range(0, span);
         if ($urandom_range(0, 15) == 0) begin
            send_query(command, ax + sx, ay + sy, az + sz, ax, ay, az,
                       $urandom_range(0, span));
         end else begin
            send_query(command, ax, ay, az, ax + sx, ay + sy, az + sz,
                       $urandom_range(0, span));
         end
      end
   endtask

   task automatic write_plane(input csr_index_type index,
                              input logic [fct_pkg::PLANE_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index < fct_pkg::NUM_PLANES) plane_shadow[index] = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // all planes zero after reset
   task automatic test_reset_planes;
      send_query(fct_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
      send_query(fct_pkg::CMD_BOX, 5, -7, 9, -3, 2, 1, 0);
      send_query(fct_pkg::CMD_SPHERE, 100, -100, 3, 0, 0, 0, 0);
      send_query(fct_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, RADIUS_MAX);
      send_query(CMD_RESERVED, COORD_MIN, COORD_MAX, -1, 0, 0, 0, 1);
      wait_drained;
   endtask

   task automatic test_directed_cube;
      write_plane(PLANE_LEFT, pack_plane(UNIT_NORMAL, 0, 0, CUBE_HALF));
      write_plane(PLANE_RIGHT, pack_plane(-UNIT_NORMAL, 0, 0, CUBE_HALF));
      write_plane(PLANE_BOTTOM, pack_plane(0, UNIT_NORMAL, 0, CUBE_HALF));
      write_plane(PLANE_TOP, pack_plane(0, -UNIT_NORMAL, 0, CUBE_HALF));
      write_plane(PLANE_NEAR, pack_plane(0, 0, UNIT_NORMAL, CUBE_HALF));
      write_plane(PLANE_FAR, pack_plane(0, 0, -UNIT_NORMAL, CUBE_HALF));
      write_plane(CSR_SPARE_A, '1);
      write_plane(CSR_SPARE_B, pack_plane(NORMAL_MIN, NORMAL_MIN, NORMAL_MIN, COORD_MIN));
      send_query(fct_pkg::CMD_POINT, 0, 0, 0, COORD_MAX, COORD_MIN, 7, RADIUS_MAX);
      send_query(fct_pkg::CMD_POINT, -CUBE_HALF, 0, 0, 0, 0, 0, 0);
      send_query(fct_pkg::CMD_POINT, -CUBE_HALF - 1, 0, 0, 0, 0, 0, 0);
      send_query(fct_pkg::CMD_POINT, 0, 0, CUBE_HALF + 1, 0, 0, 0, 0);
      send_query(CMD_RESERVED, 0, 0, 0, 0, 0, 0, 0);
      send_query(CMD_RESERVED, 2 * CUBE_HALF, 0, 0, 0, 0, 0, 0);
      send_query(fct_pkg::CMD_BOX, -10, -10, -10, 10, 10, 10, 0);
      send_query(fct_pkg::CMD_BOX, -2 * CUBE_HALF, -10, -10, 0, 10, 10, 0);
      send_query(fct_pkg::CMD_BOX, CUBE_HALF + 500, 0, 0, CUBE_HALF + 600, 10, 10, 0);
      send_query(fct_pkg::CMD_BOX, 10, 10, 10, -10, -10, -10, RADIUS_MAX);
      send_query(fct_pkg::CMD_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MAX, COORD_MAX, COORD_MAX, 0);
      send_query(fct_pkg::CMD_SPHERE, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0);
      send_query(fct_pkg::CMD_SPHERE, CUBE_HALF - 10, 0, 0, 0, 0, 0, 10);
      send_query(fct_pkg::CMD_SPHERE, CUBE_HALF - 10, 0, 0, 0, 0, 0, 11);
      send_query(fct_pkg::CMD_SPHERE, CUBE_HALF + 10, 0, 0, 0, 0, 0, 10);
      send_query(fct_pkg::CMD_SPHERE, CUBE_HALF + 10, 0, 0, 0, 0, 0, 9);
      send_query(fct_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, RADIUS_MAX);
      send_query(fct_pkg::CMD_SPHERE, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, RADIUS_MAX);
      send_query(fct_pkg::CMD_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0);
      send_query(fct_pkg::CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0);
      wait_drained;
   endtask

   task automatic test_extreme_planes;
      logic [fct_pkg::PLANE_WIDTH-1:0] plane_values [6];
      plane_values = '{'1,
                       pack_plane(NORMAL_MAX, NORMAL_MAX, NORMAL_MAX, COORD_MAX),
                       pack_plane(NORMAL_MIN, NORMAL_MIN, NORMAL_MIN, COORD_MIN),
                       {32{2'b10}},
                       {32{2'b01}},
                       pack_plane(NORMAL_MAX, NORMAL_MIN, 0, 0)};
      foreach (plane_values[k]) begin
         for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            write_plane(csr_index_type'(i), plane_values[k]);
         end
         repeat (8) send_random_query($urandom_range(16, 200000));
         wait_drained;
      end
   endtask

   task automatic test_random_planes;
      repeat (2) begin
         for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            write_plane(csr_index_type'(i), {$urandom, $urandom});
         end
         repeat (30) send_random_query($urandom_range(16, 200000));
         wait_drained;
      end
   endtask

   task automatic test_random_frustums(input int phases, input int per_phase);
      int span, axis;
      int comp [3];
      for (int p = 0; p < phases; p++) begin
         idle_bursts = (p % 3 != 2) && (p < phases - 1);
         span = ($urandom_range(0, 1) == 0) ? $urandom_range(16, 2000)
                                            : $urandom_range(2000, 200000);
         for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            axis = i / 2;
            for (int k = 0; k < 3; k++) comp[k] = rand_signed(1024);
            comp[axis] = $urandom_range(UNIT_NORMAL / 2, NORMAL_MAX);
            if (i % 2 == 1) comp[axis] = -comp[axis];
            write_plane(csr_index_type'(i),
                        pack_plane(comp[0], comp[1], comp[2], span + rand_signed(span / 4)));
         end
         if ($urandom_range(0, 1) == 0) begin
            write_plane(csr_index_type'($urandom_range(CSR_SPARE_A, CSR_SPARE_B)),
                        {$urandom, $urandom});
         end
         repeat (per_phase) send_random_query(span);
         wait_drained;
      end
   endtask

   initial begin
      foreach (plane_shadow[i]) plane_shadow[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idle_bursts = 1'b1;
      test_reset_planes;
      test_directed_cube;
      test_extreme_planes;
      test_random_planes;
      test_random_frustums(6, 55);
      wait_drained;
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ frustum_cull_test_core.f @@
sv/fct_pkg.sv
sv/fct_plane_eval.sv
sv/frustum_cull_test_core.sv
sim/tb.sv
